// ----- sv/gus_pkg.sv -----
// Shared types and constants for the unsharp-mask sharpening block.
`timescale 1ns / 1ps
package gus_pkg;
  localparam int unsigned NUM_REGS = 8;
  localparam logic [2:0] REG_WIDTH  = 3'd0;
  localparam logic [2:0] REG_HEIGHT = 3'd1;
  localparam logic [2:0] REG_W0     = 3'd2;
  localparam logic [2:0] REG_W1     = 3'd3;
  localparam logic [2:0] REG_W2     = 3'd4;
  localparam logic [2:0] REG_W4     = 3'd5;
  localparam logic [2:0] REG_W5     = 3'd6;
  localparam logic [2:0] REG_W8     = 3'd7;
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  // One output position handed from the front end to the filter engine.
  typedef struct packed {
    logic [15:0] orow;
    logic [12:0] ocol;
    logic        last;
  } gus_job_t;

  // Weight index for squared distance of tap (dx,dy), dx,dy in -2..2.
  function automatic logic [2:0] wsel(input logic [2:0] dx, input logic [2:0] dy);
    logic [1:0] ax;
    logic [1:0] ay;
    logic [3:0] d;
    begin
      ax = dx[2] ? 2'(-dx) : dx[1:0];
      ay = dy[2] ? 2'(-dy) : dy[1:0];
      d = ({2'b0, ax} * {2'b0, ax}) + ({2'b0, ay} * {2'b0, ay});
      unique case (d)
        4'd0: wsel = 3'd0;
        4'd1: wsel = 3'd1;
        4'd2: wsel = 3'd2;
        4'd4: wsel = 3'd3;
        4'd5: wsel = 3'd4;
        default: wsel = 3'd5;
      endcase
    end
  endfunction

  function automatic logic [7:0] sharpen(input logic [7:0] orig, input logic [7:0] blur);
    logic [7:0] hi;
    logic signed [10:0] v;
    begin
      hi = orig - blur + 8'd128;
      v = $signed({3'b0, orig}) + $signed({3'b0, hi}) - 11'sd170;
      if (v < 0) sharpen = 8'd0;
      else if (v > 11'sd255) sharpen = 8'd255;
      else sharpen = v[7:0];
    end
  endfunction
endpackage

// ----- sv/gus_front.sv -----
// Front end: accepts items, writes the line store, queues output positions.
`timescale 1ns / 1ps
module gus_front #(
  parameter int MAX_WIDTH = 2048,
  parameter int CW = $clog2(MAX_WIDTH) + 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 cmd,
  input  logic [23:0]          pixel,
  input  logic [CW-1:0]        w,
  input  logic [15:0]          h,
  input  logic                 res_done,
  output logic                 wr_en,
  output logic [2:0]           wr_row,
  output logic [CW-2:0]        wr_col,
  output logic [23:0]          wr_data,
  output logic                 job_valid,
  input  logic                 job_ready,
  output gus_pkg::gus_job_t    job
);
  import gus_pkg::*;
  logic [CW-1:0] icol_r, ocol_r;
  logic [16:0]   irow_r;
  logic [15:0]   orow_r;
  logic [CW+1:0] lag_r;  // items ahead of the output position
  logic          jv_r;
  gus_job_t      job_r;
  logic [1:0]    fly_r;  // positions emitted whose result is not yet out
  logic          lastp_r;
  logic          clr, live, adv, emit, olast;
  logic [CW-1:0] icol_c, ocol_n;
  logic [16:0]   irow_c;
  logic [15:0]   orow_c, orow_n;
  logic [CW+1:0] lag_c;

  // Hold input while two positions are in flight or a frame's last one is,
  // so the line store never overwrites rows the engine still reads.
  assign in_ready = (!jv_r || job_ready) &&
                    (fly_r == 2'd0 || (fly_r == 2'd1 && !lastp_r));
  assign clr = ({1'b0, orow_r} >= {1'b0, h});
  always_comb begin
    icol_c = clr ? '0 : icol_r;
    irow_c = clr ? '0 : irow_r;
    orow_c = clr ? '0 : orow_r;
    lag_c  = clr ? '0 : lag_r;
    live = irow_c < {1'b0, h};
    adv  = in_valid && in_ready && !(live && cmd == CMD_DRAIN);
    emit = adv && (lag_c >= (CW+2)'({w, 1'b0}) + (CW+2)'(2));
    ocol_n = (clr ? '0 : ocol_r) + 1'b1;
    orow_n = orow_c;
    if (ocol_n >= w) begin
      ocol_n = '0;
      orow_n = orow_c + 16'd1;
    end
    olast = orow_n >= h;
  end
  assign wr_en   = adv && live;
  assign wr_row  = irow_c[2:0];
  assign wr_col  = icol_c[CW-2:0];
  assign wr_data = pixel;
  assign job_valid = jv_r;
  assign job = job_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      icol_r <= '0; irow_r <= '0; ocol_r <= '0; orow_r <= '0; lag_r <= '0; jv_r <= 1'b0;
      fly_r <= '0; lastp_r <= 1'b0;
    end else begin
      fly_r <= fly_r + 2'(emit) - 2'(res_done);
      if (emit) lastp_r <= olast;
      else if (fly_r == 2'd1 && res_done) lastp_r <= 1'b0;
      if (job_ready) jv_r <= 1'b0;
      if (in_valid && in_ready) begin
        icol_r <= icol_c; irow_r <= irow_c; orow_r <= orow_c; lag_r <= lag_c;
        if (clr) ocol_r <= '0;
      end
      if (adv) begin
        if (icol_c + 1'b1 >= w) begin
          icol_r <= '0; irow_r <= irow_c + 17'd1;
        end else icol_r <= icol_c + 1'b1;
        lag_r <= emit ? lag_c : lag_c + 1'b1;
      end
      if (emit) begin
        jv_r <= 1'b1;
        job_r.orow <= orow_c;
        job_r.ocol <= 13'(clr ? '0 : ocol_r);
        job_r.last <= olast;
        if (olast) begin
          icol_r <= '0; irow_r <= '0; ocol_r <= '0; orow_r <= '0; lag_r <= '0;
        end else begin
          ocol_r <= ocol_n; orow_r <= orow_n;
        end
      end
    end
  end
endmodule

// ----- sv/gus_queue.sv -----
// Short queue of output positions between front end and filter engine.
`timescale 1ns / 1ps
module gus_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_valid,
  output logic              wr_ready,
  input  gus_pkg::gus_job_t wr_data,
  output logic              rd_valid,
  input  logic              rd_ready,
  output gus_pkg::gus_job_t rd_data
);
  import gus_pkg::*;
  gus_job_t   mem_r [4];
  logic [1:0] wp_r, rp_r;
  logic [2:0] cnt_r;
  logic       push, pop;
  assign wr_ready = cnt_r != 3'd4;
  assign rd_valid = cnt_r != 3'd0;
  assign rd_data  = mem_r[rp_r];
  assign push = wr_valid && wr_ready;
  assign pop  = rd_valid && rd_ready;
  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wr_data;
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 2'd1;
      if (pop) rp_r <= rp_r + 2'd1;
      cnt_r <= cnt_r + 3'(push) - 3'(pop);
    end
  end
endmodule

// ----- sv/gus_div.sv -----
// Restoring divider: 32-bit dividend, 21-bit divisor, 8-bit floored quotient.
`timescale 1ns / 1ps
module gus_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] num,
  input  logic [20:0] den,
  output logic        done,
  output logic [7:0]  quo
);
  // Quotient never exceeds 255 since num <= 255*den; eight steps suffice.
  logic [31:0] rem_r;
  logic [20:0] den_r;
  logic [7:0]  q_r;
  logic [3:0]  k_r;
  logic        busy_r;
  logic [31:0] trial;
  assign trial = rem_r - ({11'd0, den_r} << (k_r - 4'd1));
  assign done = busy_r && k_r == 4'd0;
  assign quo = q_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; k_r <= '0;
    end else if (start) begin
      busy_r <= 1'b1; k_r <= 4'd8; rem_r <= num; den_r <= den; q_r <= '0;
    end else if (busy_r && k_r != 0) begin
      k_r <= k_r - 4'd1;
      if (rem_r >= ({11'd0, den_r} << (k_r - 4'd1))) begin
        rem_r <= trial; q_r <= {q_r[6:0], 1'b1};
      end else q_r <= {q_r[6:0], 1'b0};
    end else busy_r <= 1'b0;
  end
endmodule

// ----- sv/gus_back.sv -----
// Filter engine: walks the 25 taps, divides per channel, sharpens, registers out.
`timescale 1ns / 1ps
module gus_back #(
  parameter int MAX_WIDTH = 2048,
  parameter int CW = $clog2(MAX_WIDTH) + 1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [CW-1:0]      w,
  input  logic [15:0]        h,
  input  logic [15:0]        wt [6],
  input  logic               wr_en,
  input  logic [2:0]         wr_row,
  input  logic [CW-2:0]      wr_col,
  input  logic [23:0]        wr_data,
  input  logic               job_valid,
  output logic               job_ready,
  input  gus_pkg::gus_job_t  job,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [24:0]        out_data
);
  import gus_pkg::*;
  typedef enum logic [2:0] {IDLE, TAP, ACC, DIV, DONE} st_t;
  st_t st_r;
  logic [23:0] mem [8*(2**(CW-1))];
  logic [23:0] rd_r, ctr_r;
  logic [2:0]  dx_r, dy_r, pdx_r, pdy_r;
  logic        pin_r, pend_r;
  logic [31:0] acc_r [3];
  logic [20:0] ws_r;
  logic [1:0]  ch_r;
  logic [7:0]  res_r [3];
  gus_job_t    j_r;
  logic        ov_r;
  logic [24:0] od_r;
  logic        dgo_r;
  logic signed [17:0] r, c;
  logic        inb, dstart, ddone;
  logic [7:0]  dq, orig;
  logic [15:0] tw;
  logic [CW+1:0] ra;

  always_comb begin
    r = $signed({2'b0, j_r.orow}) + 18'(signed'(dy_r));
    c = $signed({5'b0, j_r.ocol}) + 18'(signed'(dx_r));
    inb = r >= 0 && c >= 0 && r < $signed({2'b0, h}) && c < $signed(18'(w));
    ra = {r[2:0], c[CW-2:0]};
    tw = wt[wsel(pdx_r, pdy_r)];
    orig = ctr_r[8*ch_r +: 8];
  end
  always_ff @(posedge clk) begin
    if (wr_en) mem[{wr_row, wr_col}] <= wr_data;
    rd_r <= mem[ra];
  end

  // Start the first division once the last tap has been folded in.
  assign dstart = dgo_r || (ddone && ch_r != 2'd2);
  gus_div u_div (.clk, .rst_n, .start(dstart), .num(acc_r[dgo_r ? 2'd0 : ch_r + 2'd1]),
    .den(ws_r), .done(ddone), .quo(dq));

  assign job_ready = st_r == IDLE;
  assign out_valid = ov_r;
  assign out_data = od_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= IDLE; ov_r <= 1'b0; pend_r <= 1'b0; dgo_r <= 1'b0;
    end else begin
      dgo_r <= 1'b0;
      if (out_ready) ov_r <= 1'b0;
      unique case (st_r)
        IDLE: if (job_valid) begin
          j_r <= job; dx_r <= 3'd6; dy_r <= 3'd6; pend_r <= 1'b0;
          acc_r[0] <= '0; acc_r[1] <= '0; acc_r[2] <= '0; ws_r <= '0; st_r <= TAP;
        end
        TAP: begin
          // rd_r holds the tap issued last cycle
          pend_r <= 1'b1; pin_r <= inb; pdx_r <= dx_r; pdy_r <= dy_r;
          if (pend_r && pin_r) begin
            for (int k = 0; k < 3; k++) acc_r[k] <= acc_r[k] + rd_r[8*k +: 8] * tw;
            ws_r <= ws_r + 21'(tw);
          end
          if (pend_r && pdx_r == 3'd0 && pdy_r == 3'd0) ctr_r <= rd_r;
          if (dx_r == 3'd2) begin
            dx_r <= 3'd6;
            if (dy_r == 3'd2) st_r <= ACC; else dy_r <= dy_r + 3'd1;
          end else dx_r <= dx_r + 3'd1;
        end
        ACC: begin
          if (pin_r) begin
            for (int k = 0; k < 3; k++) acc_r[k] <= acc_r[k] + rd_r[8*k +: 8] * tw;
            ws_r <= ws_r + 21'(tw);
          end
          ch_r <= 2'd0; dgo_r <= 1'b1; st_r <= DIV;
        end
        DIV: if (ddone) begin
          res_r[ch_r] <= sharpen(orig, ws_r == 0 ? orig : dq);
          if (ch_r == 2'd2) st_r <= DONE; else ch_r <= ch_r + 2'd1;
        end
        DONE: if (!ov_r || out_ready) begin
          ov_r <= 1'b1; od_r <= {j_r.last, res_r[2], res_r[1], res_r[0]}; st_r <= IDLE;
        end
        default: st_r <= IDLE;
      endcase
    end
  end
endmodule

// ----- sv/gaussian_unsharp_sharpen.sv -----
// Top level of the 5x5 Gaussian unsharp-mask sharpener with its register file.
`timescale 1ns / 1ps
// RGB pixels enter in raster order; each result is the sharpened pixel lagging
// 2*width+2 inputs behind, and drain items (cmd=1) flush the tail of a frame.
// The front end takes one item a cycle while at most one output position is
// in flight, and holds input while two are, or while a frame's last position
// has not left the result port, so the line store keeps every row still read.
// In the filter engine each result takes the position, makes 25 tap reads, one
// per cycle, from the line store (one read port beside its write port), folds in
// the last tap, runs three 8-step divisions, one per channel, and loads the
// output register, where output stalls can hold it. The line store is 8 rows of
// MAX_WIDTH pixels, never cleared.
module gaussian_unsharp_sharpen #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // pixel_red, pixel_green, pixel_blue
  input  logic        in_tuser,   // cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // sharp_red, sharp_green, sharp_blue
  output logic        out_tlast,  // frame_last
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import gus_pkg::*;
  localparam int CW = $clog2(MAX_WIDTH) + 1;
  logic [11:0] width_r;
  logic [15:0] height_r;
  logic [15:0] wt_r [6];
  logic [CW-1:0] w;
  logic [15:0] h;
  logic wr_en, jv, jr, qv, qr, odone;
  logic [2:0] wr_row;
  logic [CW-2:0] wr_col;
  logic [23:0] wr_data;
  gus_job_t job, qjob;
  logic [24:0] od;
  logic [2:0] ri;

  assign cfg_pready = 1'b1;
  assign ri = cfg_paddr[4:2];
  always_comb begin
    unique case (ri)
      REG_WIDTH:  cfg_prdata = {20'd0, width_r};
      REG_HEIGHT: cfg_prdata = {16'd0, height_r};
      default:    cfg_prdata = {16'd0, wt_r[ri - REG_W0]};
    endcase
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= 12'd2048; height_r <= 16'd1;
      wt_r[0] <= 16'd65535; wt_r[1] <= 16'd52477; wt_r[2] <= 16'd42020;
      wt_r[3] <= 16'd26942; wt_r[4] <= 16'd21573; wt_r[5] <= 16'd11076;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      unique case (ri)
        REG_WIDTH:  width_r <= cfg_pwdata[11:0];
        REG_HEIGHT: height_r <= cfg_pwdata[15:0];
        default:    wt_r[ri - REG_W0] <= cfg_pwdata[15:0];
      endcase
    end
  end
  always_comb begin
    if (width_r == 12'd0) w = CW'(1);
    else if ({20'd0, width_r} > 32'(MAX_WIDTH)) w = CW'(MAX_WIDTH);
    else w = CW'(width_r);
    h = (height_r == 16'd0) ? 16'd1 : height_r;
  end

  assign odone = out_tvalid && out_tready;

  gus_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (.clk, .rst_n, .in_valid(in_tvalid),
    .in_ready(in_tready), .cmd(in_tuser), .pixel(in_tdata), .w, .h, .res_done(odone),
    .wr_en, .wr_row, .wr_col, .wr_data, .job_valid(jv), .job_ready(jr), .job);
  gus_queue u_q (.clk, .rst_n, .wr_valid(jv), .wr_ready(jr), .wr_data(job),
    .rd_valid(qv), .rd_ready(qr), .rd_data(qjob));
  gus_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (.clk, .rst_n, .w, .h, .wt(wt_r), .wr_en,
    .wr_row, .wr_col, .wr_data, .job_valid(qv), .job_ready(qr), .job(qjob),
    .out_valid(out_tvalid), .out_ready(out_tready), .out_data(od));
  assign out_tdata = od[23:0];
  assign out_tlast = od[24];
endmodule

// ----- sv/gus_checker.sv -----
// Port-level checks for the sharpener, bound to the top level.
`timescale 1ns / 1ps
module gus_checker (
  input logic clk, rst_n, in_tvalid, in_tready, out_tvalid, out_tready, out_tlast,
  input logic cfg_pready,
  input logic [23:0] out_tdata
);
  a_pready: assert property (@(posedge clk) cfg_pready) else $error("pready low");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output changed while stalled");
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");
  a_rdy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid |-> !$isunknown(in_tready))
    else $error("input ready unknown");
endmodule
bind gaussian_unsharp_sharpen gus_checker u_chk (.clk, .rst_n, .in_tvalid, .in_tready,
  .out_tvalid, .out_tready, .out_tlast, .cfg_pready, .out_tdata);

// ----- tb/gaussian_unsharp_sharpen_test.sv -----
// Self-checking testbench for the 5x5 Gaussian unsharp-mask sharpener.
`timescale 1ns / 1ps
module gaussian_unsharp_sharpen_test;
  import gus_pkg::*;

  localparam int MAXW = 2048;

  // One expected output pixel: red, green, blue and the end-of-frame flag.
  typedef struct packed {
    logic       last;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } sharp_px_t;

  typedef struct {
    bit          is_cfg;
    logic [2:0]  reg_idx;
    logic [31:0] reg_val;
    logic        cmd;
    logic [23:0] rgb;
    bit          typed;
    sharp_px_t   px;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;   // pixel_red, pixel_green, pixel_blue
  logic        in_tuser = 1'b0; // cmd
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;       // sharp_red, sharp_green, sharp_blue
  logic        out_tlast;       // frame_last
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [4:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  gaussian_unsharp_sharpen u_dut (.*);

  always #1 clk = ~clk;

  // Shadow of the block: registers, pixel rows and raster counters.
  logic [11:0] img_w;
  logic [15:0] img_h;
  logic [15:0] wgt [6];
  logic [23:0] rows [8][MAXW];
  int unsigned in_col, in_row, out_col, out_row;

  sharp_px_t   sharp_q[$];
  stim_row_t   dir_tab[$];
  int          mismatches = 0;
  bit          quiet = 1'b0;
  int          hold = 0;

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [7:0] unsharp(input int orig, input int blur);
    int hi;
    int v;
    hi = (orig - blur + 128) & 255;
    v = orig + hi - 170;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[7:0];
  endfunction

  // Advance the raster model by one item; return 1 when it yields a pixel.
  function automatic bit sharpen_step(input logic cmd, input logic [23:0] rgb,
                                      output sharp_px_t px);
    int unsigned w, h, n, m, wsum, wt, d;
    int unsigned acc [3];
    int r, c;
    logic [23:0] tap, ctr;
    w = (img_w == 0) ? 1 : ((img_w > MAXW) ? MAXW : img_w);
    h = (img_h == 0) ? 1 : img_h;
    px = '0;
    if (out_row >= h) begin
      in_col = 0; in_row = 0; out_col = 0; out_row = 0;
    end
    if (in_row < h) begin
      if (cmd == CMD_DRAIN) return 0;
      rows[in_row % 8][in_col] = rgb;
    end
    n = in_row * w + in_col;
    in_col++;
    if (in_col >= w) begin
      in_col = 0;
      in_row++;
    end
    m = out_row * w + out_col;
    if (n < m + 2 * w + 2) return 0;
    acc = '{0, 0, 0};
    wsum = 0;
    for (int j = -2; j <= 2; j++) begin
      for (int i = -2; i <= 2; i++) begin
        r = int'(out_row) + j;
        c = int'(out_col) + i;
        if (r < 0 || c < 0 || r >= int'(h) || c >= int'(w)) continue;
        tap = rows[r % 8][c];
        d = i * i + j * j;
        case (d)
          0: wt = wgt[0];
          1: wt = wgt[1];
          2: wt = wgt[2];
          4: wt = wgt[3];
          5: wt = wgt[4];
          default: wt = wgt[5];
        endcase
        for (int k = 0; k < 3; k++) acc[k] += tap[8*k +: 8] * wt;
        wsum += wt;
      end
    end
    ctr = rows[out_row % 8][out_col];
    px.red   = unsharp(ctr[7:0],   (wsum == 0) ? ctr[7:0]   : acc[0] / wsum);
    px.green = unsharp(ctr[15:8],  (wsum == 0) ? ctr[15:8]  : acc[1] / wsum);
    px.blue  = unsharp(ctr[23:16], (wsum == 0) ? ctr[23:16] : acc[2] / wsum);
    out_col++;
    if (out_col >= w) begin
      out_col = 0;
      out_row++;
    end
    if (out_row >= h) begin
      px.last = 1'b1;
      in_col = 0; in_row = 0; out_col = 0; out_row = 0;
    end
    return 1;
  endfunction

  // Write one register once every expected pixel is out and the engine is quiet.
  task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
    while (sharp_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    @(negedge clk);
    cfg_psel = 1'b1; cfg_pwrite = 1'b1; cfg_penable = 1'b0;
    cfg_paddr = {idx, 2'b00}; cfg_pwdata = val;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel = 1'b0; cfg_penable = 1'b0; cfg_pwrite = 1'b0;
    case (idx)
      REG_WIDTH:  img_w = val[11:0];
      REG_HEIGHT: img_h = val[15:0];
      default:    wgt[idx - REG_W0] = val[15:0];
    endcase
  endtask

  // Drive one item (already at a falling edge) and model it once accepted.
  task automatic send_item(input logic cmd, input logic [23:0] rgb, input bit typed,
                           input sharp_px_t typed_px, output bit frame_done);
    int g;
    sharp_px_t px;
    g = gap_len();
    if (g > 0) begin
      in_tvalid = 1'b0;
      repeat (g) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser = cmd;
    in_tdata = rgb;
    do @(posedge clk); while (!in_tready);
    frame_done = 1'b0;
    if (sharpen_step(cmd, rgb, px)) begin
      sharp_q.push_back(typed ? typed_px : px);
      frame_done = px.last;
    end
    @(negedge clk);
  endtask

  task automatic idle_input();
    in_tvalid = 1'b0;
  endtask

  function automatic stim_row_t cfg_row(input logic [2:0] idx, input logic [31:0] val);
    stim_row_t s;
    s = '{default: '0};
    s.is_cfg = 1'b1; s.reg_idx = idx; s.reg_val = val;
    return s;
  endfunction

  function automatic stim_row_t px_row(input logic cmd, input logic [23:0] rgb,
                                       input bit typed, input sharp_px_t px);
    stim_row_t s;
    s = '{default: '0};
    s.cmd = cmd; s.rgb = rgb; s.typed = typed; s.px = px;
    return s;
  endfunction

  // Result side: random back-pressure, checked at the rising edge.
  always @(negedge clk) begin
    if (hold > 0) begin
      out_tready <= 1'b0;
      hold <= hold - 1;
    end else begin
      out_tready <= 1'b1;
      if ($urandom_range(0, 7) == 0) hold <= gap_len();
    end
  end

  always @(posedge clk) begin
    sharp_px_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (sharp_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected pixel %h last %b", out_tdata, out_tlast);
      end else begin
        want = sharp_q.pop_front();
        if (out_tdata[7:0] !== want.red || out_tdata[15:8] !== want.green ||
            out_tdata[23:16] !== want.blue || out_tlast !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("pixel mismatch: expected r%h g%h b%h last %b, got r%h g%h b%h last %b",
                     want.red, want.green, want.blue, want.last,
                     out_tdata[7:0], out_tdata[15:8], out_tdata[23:16], out_tlast);
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("gaussian_unsharp_sharpen_test failed");
    $finish;
  end

  initial begin
    int sent;
    bit done;
    logic [2:0] ri;
    img_w = 12'd2048; img_h = 16'd1;
    wgt = '{16'd65535, 16'd52477, 16'd42020, 16'd26942, 16'd21573, 16'd11076};
    in_col = 0; in_row = 0; out_col = 0; out_row = 0;

    // Single-pixel frames see only the center tap, so blur equals the pixel
    // and each channel comes out as orig - 42, clamped.
    dir_tab.push_back(cfg_row(REG_WIDTH, 32'd1));
    dir_tab.push_back(cfg_row(REG_HEIGHT, 32'd1));
    dir_tab.push_back(px_row(CMD_DRAIN, 24'h123456, 0, '0)); // drain inside frame: drop
    dir_tab.push_back(px_row(CMD_PIXEL, 24'h6400FF, 0, '0));
    repeat (3) dir_tab.push_back(px_row(CMD_DRAIN, 24'hFFFFFF, 0, '0));
    dir_tab.push_back(px_row(CMD_DRAIN, 24'h000000, 1, '{1'b1, 8'd58, 8'd0, 8'd213}));
    // Width and height of zero behave as one; pixels past the frame act as drains.
    dir_tab.push_back(cfg_row(REG_WIDTH, 32'd0));
    dir_tab.push_back(cfg_row(REG_HEIGHT, 32'd0));
    dir_tab.push_back(px_row(CMD_PIXEL, 24'hFF2B2A, 0, '0));
    repeat (3) dir_tab.push_back(px_row(CMD_PIXEL, 24'hA5A5A5, 0, '0));
    dir_tab.push_back(px_row(CMD_PIXEL, 24'h5A5A5A, 1, '{1'b1, 8'd213, 8'd1, 8'd0}));
    // All weights zero: blur falls back to the pixel itself.
    for (int k = 0; k < 6; k++) dir_tab.push_back(cfg_row(3'(REG_W0 + k), 32'd0));
    dir_tab.push_back(cfg_row(REG_WIDTH, 32'd2));
    dir_tab.push_back(px_row(CMD_PIXEL, 24'h32C80A, 0, '0));
    dir_tab.push_back(px_row(CMD_PIXEL, 24'h2B2AFF, 0, '0));
    repeat (4) dir_tab.push_back(px_row(CMD_DRAIN, 24'h0, 0, '0));
    dir_tab.push_back(px_row(CMD_DRAIN, 24'h0, 1, '{1'b0, 8'd8, 8'd158, 8'd0}));
    dir_tab.push_back(px_row(CMD_DRAIN, 24'h0, 1, '{1'b1, 8'd1, 8'd0, 8'd213}));

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_cfg) begin
        idle_input();
        reg_write(dir_tab[i].reg_idx, dir_tab[i].reg_val);
      end else begin
        send_item(dir_tab[i].cmd, dir_tab[i].rgb, dir_tab[i].typed, dir_tab[i].px, done);
      end
    end

    // Random frames: mostly small, well-formed rasters with stray drains mixed in.
    sent = 0;
    while (sent < 1500) begin
      idle_input();
      quiet = ($urandom_range(0, 4) == 0);
      case ($urandom_range(0, 9))
        0: reg_write(REG_WIDTH, $urandom_range(0, 1) ? 32'd0 : 32'd1);
        1, 2: reg_write(REG_WIDTH, $urandom_range(11, 40));
        default: reg_write(REG_WIDTH, $urandom_range(1, 10));
      endcase
      case ($urandom_range(0, 9))
        0: reg_write(REG_HEIGHT, 32'd0);
        1: reg_write(REG_HEIGHT, $urandom_range(7, 20));
        default: reg_write(REG_HEIGHT, $urandom_range(1, 6));
      endcase
      for (int k = 0; k < 6; k++) begin
        ri = 3'(REG_W0 + k);
        case ($urandom_range(0, 9))
          0: reg_write(ri, 32'd0);
          1: reg_write(ri, 32'd65535);
          default: reg_write(ri, $urandom_range(1, 65535));
        endcase
      end
      for (int p = 0; p < (img_w == 0 ? 1 : img_w) * (img_h == 0 ? 1 : img_h); p++) begin
        if ($urandom_range(0, 24) == 0) send_item(CMD_DRAIN, $urandom(), 0, '0, done);
        send_item(CMD_PIXEL, $urandom(), 0, '0, done);
        sent++;
      end
      done = 1'b0;
      while (!done) begin
        send_item($urandom_range(0, 4) != 0 ? CMD_DRAIN : CMD_PIXEL, $urandom(), 0, '0, done);
        sent++;
      end
    end
    idle_input();
    quiet = 1'b0;

    while (sharp_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatches == 0) begin
      $display("gaussian_unsharp_sharpen_test passed");
    end else begin
      $display("gaussian_unsharp_sharpen_test failed");
    end
    $finish;
  end
endmodule

// ----- files.f -----
sv/gus_pkg.sv
sv/gus_front.sv
sv/gus_queue.sv
sv/gus_div.sv
sv/gus_back.sv
sv/gaussian_unsharp_sharpen.sv
sv/gus_checker.sv
tb/gaussian_unsharp_sharpen_test.sv
